/* rtl/pcc_pkg.sv */
// Shared constants, types and codes of the plane crossing counter.
package pcc_pkg;

  localparam int unsigned MaxParticles = 4096;
  localparam int unsigned IdxW         = 12;
  localparam int unsigned StoreDepth   = (MaxParticles < (1 << IdxW)) ? MaxParticles
                                                                      : (1 << IdxW);
  localparam int unsigned AddrW        = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  localparam int unsigned PosW  = 24;
  localparam int unsigned NrmW  = 16;
  localparam int unsigned DiffW = PosW + 1;
  localparam int unsigned ProdW = DiffW + NrmW;
  localparam int unsigned SumW  = ProdW + 2;
  localparam int unsigned CntW  = 13;
  localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  // register indexes (paddr[4:2])
  localparam logic [2:0] RegPointX  = 3'd0;
  localparam logic [2:0] RegPointY  = 3'd1;
  localparam logic [2:0] RegPointZ  = 3'd2;
  localparam logic [2:0] RegNormalX = 3'd3;
  localparam logic [2:0] RegNormalY = 3'd4;
  localparam logic [2:0] RegNormalZ = 3'd5;

  localparam logic [NrmW-1:0] NormalZReset = 16'sd16384;

  localparam logic CmdRecord = 1'b0;
  localparam logic CmdCheck  = 1'b1;

  typedef enum logic [1:0] {
    SideZero = 2'd0,
    SidePos  = 2'd1,
    SideNeg  = 2'd2
  } side_e;

  typedef struct packed {
    logic            cmd;
    logic [IdxW-1:0] idx;
    logic            last;
  } item_tag_t;

  typedef struct packed {
    logic signed [PosW-1:0] pt_x;
    logic signed [PosW-1:0] pt_y;
    logic signed [PosW-1:0] pt_z;
    logic signed [NrmW-1:0] n_x;
    logic signed [NrmW-1:0] n_y;
    logic signed [NrmW-1:0] n_z;
  } plane_cfg_t;

endpackage

/* rtl/pcc_dist.sv */
// Three-stage signed distance pipeline: differences, products, sum and side.
module pcc_dist import pcc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   valid_i,
  input  item_tag_t              tag_i,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic signed [PosW-1:0] pos_z_i,
  input  plane_cfg_t             cfg_i,
  output logic                   valid_o,
  output item_tag_t              tag_o,
  output side_e                  side_o
);

  logic                    v1_q, v2_q, v3_q;
  item_tag_t               tag1_q, tag2_q, tag3_q;
  logic signed [DiffW-1:0] dx_q, dy_q, dz_q;
  logic signed [ProdW-1:0] px_q, py_q, pz_q;
  logic signed [SumW-1:0]  sum_q;

  logic signed [DiffW-1:0] dx_d, dy_d, dz_d;
  logic signed [ProdW-1:0] px_d, py_d, pz_d;
  logic signed [SumW-1:0]  sum_d;

  always_comb begin
    dx_d = DiffW'(pos_x_i) - DiffW'(cfg_i.pt_x);
    dy_d = DiffW'(pos_y_i) - DiffW'(cfg_i.pt_y);
    dz_d = DiffW'(pos_z_i) - DiffW'(cfg_i.pt_z);
    px_d = dx_q * cfg_i.n_x;
    py_d = dy_q * cfg_i.n_y;
    pz_d = dz_q * cfg_i.n_z;
    sum_d = SumW'(px_q) + SumW'(py_q) + SumW'(pz_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag1_q <= tag_i;
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      dz_q   <= dz_d;
      tag2_q <= tag1_q;
      px_q   <= px_d;
      py_q   <= py_d;
      pz_q   <= pz_d;
      tag3_q <= tag2_q;
      sum_q  <= sum_d;
    end
  end

  always_comb begin
    if (sum_q[SumW-1]) begin
      side_o = SideNeg;
    end else if (sum_q == '0) begin
      side_o = SideZero;
    end else begin
      side_o = SidePos;
    end
  end

  assign valid_o = v3_q;
  assign tag_o   = tag3_q;

endmodule

/* rtl/plane_crossing_counter.sv */
// Plane crossing counter: top level with side store, count and APB registers.
//
//   channel | dir | handshake                     | payload
//   in      | in  | in_valid_i / in_ready_o       | cmd, particle_index, pos_x/y/z, last
//   out     | out | out_valid_o / out_ready_i     | crossings
//   apb     | in  | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One item per cycle while the input is not stalled. A result passes three distance
// stages, the side store read/write and the count before it shows on out_valid_o.
// The side store is one 4096x2 synchronous RAM; each item reads or writes it in
// the same stage, so no forwarding is needed. Reset clears control and count.
// Input stalls only when a result item reaches the count stage while the
// output register still holds an untaken result.
module plane_crossing_counter import pcc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   cmd_i,
  input  logic [IdxW-1:0]        particle_index_i,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic signed [PosW-1:0] pos_z_i,
  input  logic                   last_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CntW-1:0]        crossings_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ApbAddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0]    pwdata,
  output logic [ApbDataW-1:0]    prdata,
  output logic                   pready
);

  plane_cfg_t cfg_q;
  logic       cfg_wr;
  logic [2:0] reg_sel;

  logic       adv;
  item_tag_t  in_tag;
  logic       v3;
  item_tag_t  tag3;
  side_e      side3;
  logic       in_range3;

  logic [1:0] side_mem_q [StoreDepth];
  logic [1:0] rd_q;
  logic       v4_q;
  item_tag_t  tag4_q;
  side_e      side4_q;
  logic       in_range4_q;

  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic            crossed;
  logic            emit;
  logic            out_valid_q;
  logic [CntW-1:0] crossings_q;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pt_x <= '0;
      cfg_q.pt_y <= '0;
      cfg_q.pt_z <= '0;
      cfg_q.n_x  <= '0;
      cfg_q.n_y  <= '0;
      cfg_q.n_z  <= NormalZReset;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        RegPointX:  cfg_q.pt_x <= pwdata[PosW-1:0];
        RegPointY:  cfg_q.pt_y <= pwdata[PosW-1:0];
        RegPointZ:  cfg_q.pt_z <= pwdata[PosW-1:0];
        RegNormalX: cfg_q.n_x  <= pwdata[NrmW-1:0];
        RegNormalY: cfg_q.n_y  <= pwdata[NrmW-1:0];
        RegNormalZ: cfg_q.n_z  <= pwdata[NrmW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegPointX:  prdata = ApbDataW'(cfg_q.pt_x);
      RegPointY:  prdata = ApbDataW'(cfg_q.pt_y);
      RegPointZ:  prdata = ApbDataW'(cfg_q.pt_z);
      RegNormalX: prdata = ApbDataW'(cfg_q.n_x);
      RegNormalY: prdata = ApbDataW'(cfg_q.n_y);
      RegNormalZ: prdata = ApbDataW'(cfg_q.n_z);
      default:    prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // only a result item needs the output register; everything else drains
  assign emit       = v4_q && (tag4_q.cmd == CmdCheck) && tag4_q.last;
  assign adv        = !(emit && out_valid_q && !out_ready_i);
  assign in_ready_o = adv;

  assign in_tag = '{cmd: cmd_i, idx: particle_index_i, last: last_i};

  pcc_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .tag_i   (in_tag),
    .pos_x_i (pos_x_i),
    .pos_y_i (pos_y_i),
    .pos_z_i (pos_z_i),
    .cfg_i   (cfg_q),
    .valid_o (v3),
    .tag_o   (tag3),
    .side_o  (side3)
  );

  assign in_range3 = (32'(tag3.idx) < MaxParticles);

  // ---------------- side store ----------------
  // record writes and check reads happen in one stage, so order is kept
  always_ff @(posedge clk_i) begin
    if (adv && v3) begin
      if (tag3.cmd == CmdRecord && in_range3) begin
        side_mem_q[tag3.idx[AddrW-1:0]] <= side3;
      end
      rd_q <= side_mem_q[tag3.idx[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag4_q      <= tag3;
      side4_q     <= side3;
      in_range4_q <= in_range3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3;
    end
  end

  // ---------------- count and result ----------------
  always_comb begin
    crossed = v4_q && (tag4_q.cmd == CmdCheck) && in_range4_q &&
              (((rd_q == SidePos) && (side4_q == SideNeg)) ||
               ((rd_q == SideNeg) && (side4_q == SidePos)));
    cnt_inc = (crossed && (cnt_q != CountMax)) ? cnt_q + 1'b1 : cnt_q;
    cnt_d   = emit ? '0 : cnt_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        cnt_q <= cnt_d;
      end
      if (adv && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      crossings_q <= cnt_inc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign crossings_o = crossings_q;

endmodule

/* rtl/pcc_checker.sv */
// Port-level checker for the plane crossing counter, bound to the top level.
module pcc_checker import pcc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   cmd_i,
  input logic [IdxW-1:0]        particle_index_i,
  input logic signed [PosW-1:0] pos_x_i,
  input logic signed [PosW-1:0] pos_y_i,
  input logic signed [PosW-1:0] pos_z_i,
  input logic                   last_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [CntW-1:0]        crossings_o,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [ApbAddrW-1:0]    paddr,
  input logic [ApbDataW-1:0]    pwdata,
  input logic [ApbDataW-1:0]    prdata,
  input logic                   pready
);

  // a waiting result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(crossings_o))
    else $error("result dropped or changed while stalled");

  // input stalls only behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // a waiting input item stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i &&
      $stable({cmd_i, particle_index_i, pos_x_i, pos_y_i, pos_z_i, last_i}))
    else $error("input item dropped or changed while stalled");

  // a point x register write reads back on a read that follows it directly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr == ApbAddrW'(0)) ##1
    (psel && !pwrite && paddr == ApbAddrW'(0))
    |-> prdata[PosW-1:0] == $past(pwdata[PosW-1:0]))
    else $error("plane point x readback mismatch");

endmodule

bind plane_crossing_counter pcc_checker u_pcc_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for the plane crossing counter.
module tb_top;
  import pcc_pkg::*;

  localparam logic [PosW-1:0] PosMax   = {1'b0, {(PosW-1){1'b1}}};
  localparam logic [PosW-1:0] PosMin   = {1'b1, {(PosW-1){1'b0}}};
  localparam logic [PosW-1:0] PosNeg1  = {PosW{1'b1}};
  // stalls are short and random; a drain plus a register write stays far below this
  localparam int unsigned     QuietLimit = 2000;

  // Tracks plane setup, side per particle and the running count; holds the
  // crossing counts still owed by the block.
  class crossing_ledger;
    plane_cfg_t      plane;
    side_e           side_mem[MaxParticles];
    logic [CntW-1:0] run_count;
    logic [CntW-1:0] expected_counts[$];
    int unsigned     mismatches;

    function new();
      plane      = '0;
      plane.n_z  = NormalZReset;
      foreach (side_mem[i]) side_mem[i] = SideZero;
      run_count  = '0;
      mismatches = 0;
    endfunction

    function void set_register(logic [2:0] reg_idx, logic [ApbDataW-1:0] value);
      case (reg_idx)
        RegPointX:  plane.pt_x = value[PosW-1:0];
        RegPointY:  plane.pt_y = value[PosW-1:0];
        RegPointZ:  plane.pt_z = value[PosW-1:0];
        RegNormalX: plane.n_x  = value[NrmW-1:0];
        RegNormalY: plane.n_y  = value[NrmW-1:0];
        RegNormalZ: plane.n_z  = value[NrmW-1:0];
        default: ;
      endcase
    endfunction

    // exact signed distance; only its sign matters
    function side_e side_of(logic [PosW-1:0] x, logic [PosW-1:0] y, logic [PosW-1:0] z);
      longint dot_val;
      dot_val = (longint'($signed(x)) - longint'($signed(plane.pt_x))) * longint'($signed(plane.n_x))
              + (longint'($signed(y)) - longint'($signed(plane.pt_y))) * longint'($signed(plane.n_y))
              + (longint'($signed(z)) - longint'($signed(plane.pt_z))) * longint'($signed(plane.n_z));
      if (dot_val > 0) return SidePos;
      if (dot_val < 0) return SideNeg;
      return SideZero;
    endfunction

    function void note_item(logic cmd, logic [IdxW-1:0] idx, logic [PosW-1:0] x,
                            logic [PosW-1:0] y, logic [PosW-1:0] z, logic last);
      side_e now_side;
      side_e was_side;
      now_side = side_of(x, y, z);
      if (cmd == CmdRecord) begin
        if (idx < MaxParticles) side_mem[idx] = now_side;
        return;
      end
      if (idx < MaxParticles) begin
        was_side = side_mem[idx];
        if (((was_side == SidePos && now_side == SideNeg) ||
             (was_side == SideNeg && now_side == SidePos)) && run_count != CountMax)
          run_count++;
      end
      if (last) begin
        expected_counts.push_back(run_count);
        run_count = '0;
      end
    endfunction

    function void check_result(logic [CntW-1:0] got);
      logic [CntW-1:0] want;
      if (expected_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: crossings %0d", got);
        return;
      end
      want = expected_counts.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("crossings mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                cmd;
  logic [IdxW-1:0]     pidx;
  logic [PosW-1:0]     pos_x;
  logic [PosW-1:0]     pos_y;
  logic [PosW-1:0]     pos_z;
  logic                last;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CntW-1:0]     crossings;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  crossing_ledger  ledger;
  bit              no_idle = 1'b0;
  int unsigned     items_sent = 0;
  int unsigned     quiet_cycles = 0;
  bit              recorded[MaxParticles];
  logic [IdxW-1:0] recorded_list[$];

  plane_crossing_counter u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .cmd_i            (cmd),
    .particle_index_i (pidx),
    .pos_x_i          (pos_x),
    .pos_y_i          (pos_y),
    .pos_z_i          (pos_z),
    .last_i           (last),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .crossings_o      (crossings),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) out_ready <= no_idle || ($urandom_range(99) >= 29);

  // result check and stall watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) ledger.check_result(crossings);
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(logic c, logic [IdxW-1:0] i, logic [PosW-1:0] x,
                           logic [PosW-1:0] y, logic [PosW-1:0] z, logic l);
    while (!no_idle && $urandom_range(99) < 29) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    cmd      = c;
    pidx     = i;
    pos_x    = x;
    pos_y    = y;
    pos_z    = z;
    last     = l;
    do @(posedge clk); while (!in_ready);
    ledger.note_item(c, i, x, y, z, l);
    if (c == CmdRecord && !recorded[i]) begin
      recorded[i] = 1'b1;
      recorded_list.push_back(i);
    end
    items_sent++;
    @(negedge clk);
  endtask

  // some positions sit exactly on the plane point, so the side is zero
  task automatic send_random(logic c, logic [IdxW-1:0] i, logic l);
    if ($urandom_range(99) < 8)
      send_item(c, i, ledger.plane.pt_x, ledger.plane.pt_y, ledger.plane.pt_z, l);
    else
      send_item(c, i, PosW'($urandom()), PosW'($urandom()), PosW'($urandom()), l);
  endtask

  // drain all owed results, then give the pipeline time to empty
  task automatic settle();
    in_valid = 1'b0;
    while (ledger.expected_counts.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic apb_write(logic [2:0] reg_idx, int value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {reg_idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    ledger.set_register(reg_idx, pwdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_plane(int ptx, int pty, int ptz, int nx, int ny, int nz);
    settle();
    apb_write(RegPointX, ptx);
    apb_write(RegPointY, pty);
    apb_write(RegPointZ, ptz);
    apb_write(RegNormalX, nx);
    apb_write(RegNormalY, ny);
    apb_write(RegNormalZ, nz);
  endtask

  function automatic int rand_normal();
    if ($urandom_range(9) == 0) return 0;
    return int'($urandom_range(32768)) - 16384;
  endfunction

  function automatic int rand_point();
    return int'($urandom_range(16777215)) - 8388608;
  endfunction

  // mostly record-then-check passes; the rest single records and stray checks
  task automatic random_traffic(int unsigned count);
    int unsigned     stop_at;
    int unsigned     n;
    int unsigned     m;
    logic [IdxW-1:0] pass_idx[$];
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 75) begin
        pass_idx.delete();
        n = $urandom_range(24, 1);
        repeat (n) begin
          pass_idx.push_back(IdxW'($urandom()));
          send_random(CmdRecord, pass_idx[$], $urandom_range(9) == 0);
        end
        m = $urandom_range(n + 3, 1);
        for (int k = 0; k < m; k++)
          send_random(CmdCheck, pass_idx[$urandom_range(n - 1)], k == m - 1);
      end else if ($urandom_range(1) == 0 || recorded_list.size() == 0) begin
        send_random(CmdRecord, IdxW'($urandom()), $urandom_range(1) == 1);
      end else begin
        send_random(CmdCheck, recorded_list[$urandom_range(recorded_list.size() - 1)],
                    $urandom_range(3) == 0);
      end
    end
  endtask

  initial begin
    ledger   = new();
    in_valid = 1'b0;
    cmd      = CmdRecord;
    pidx     = '0;
    pos_x    = '0;
    pos_y    = '0;
    pos_z    = '0;
    last     = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    foreach (recorded[i]) recorded[i] = 1'b0;
    rst_n    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset plane: z = 0, normal along +z; last on a record does nothing
    send_item(CmdRecord, 0, PosMin, PosMax, PosMax, 1'b1);
    send_item(CmdRecord, 4095, PosMax, PosMin, PosMin, 1'b0);
    send_item(CmdRecord, 1, PosMax, PosMax, '0, 1'b0);
    send_item(CmdRecord, 2, '0, '0, PosW'(1), 1'b0);
    send_item(CmdCheck, 0, '0, '0, PosNeg1, 1'b0);
    send_item(CmdCheck, 4095, '0, '0, PosMax, 1'b0);
    send_item(CmdCheck, 1, '0, '0, PosMin, 1'b0);
    send_item(CmdCheck, 2, '0, '0, '0, 1'b0);
    send_item(CmdCheck, 2, PosMin, PosMin, PosMin, 1'b0);
    send_item(CmdCheck, 0, '0, '0, PosW'(5), 1'b1);
    send_item(CmdCheck, 4095, '0, '0, PosMax, 1'b1);

    set_plane(8388607, -8388608, 0, 16384, -16384, 16384);
    send_item(CmdRecord, 3, PosMin, PosMax, PosMin, 1'b0);
    send_item(CmdCheck, 3, PosMax, PosMin, PosMax, 1'b1);

    // normals beyond unit length, points at the corners
    set_plane(-8388608, 8388607, -8388608, -32768, 32767, -32768);
    send_item(CmdRecord, 4, PosMax, PosMin, PosMax, 1'b0);
    send_item(CmdRecord, 5, PosMin, PosMax, PosMin, 1'b0);
    send_item(CmdCheck, 4, PosMin, PosMax, PosMax, 1'b0);
    send_item(CmdCheck, 5, PosMax, PosMin, PosMax, 1'b1);

    // zero normal: everything lies on the plane
    set_plane(rand_point(), rand_point(), rand_point(), 0, 0, 0);
    send_item(CmdRecord, 6, PosMax, PosMax, PosMax, 1'b0);
    send_item(CmdCheck, 6, PosMin, PosMin, PosMin, 1'b1);

    // the same particle crosses on every check of a long pass
    set_plane(0, 0, 0, 0, 0, 16384);
    no_idle = 1'b1;
    send_item(CmdRecord, 7, '0, '0, PosW'(1), 1'b0);
    repeat (40) send_item(CmdCheck, 7, '0, '0, PosNeg1, 1'b0);
    send_item(CmdCheck, 7, '0, '0, PosNeg1, 1'b1);
    send_item(CmdCheck, 7, '0, '0, PosNeg1, 1'b1);
    no_idle = 1'b0;

    for (int p = 0; p < 5; p++) begin
      set_plane(rand_point(), rand_point(), rand_point(),
                rand_normal(), rand_normal(), rand_normal());
      no_idle = (p == 2);
      random_traffic(360);
    end
    no_idle = 1'b0;

    in_valid = 1'b0;
    while (ledger.expected_counts.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (ledger.mismatches == 0 && ledger.expected_counts.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
